FILE: hw/rtl/ip_prefix_acl_match_macros.svh
// Assertion macros used by the RTL of the prefix access list.
`ifndef IP_PREFIX_ACL_MATCH_MACROS_SVH
`define IP_PREFIX_ACL_MATCH_MACROS_SVH

// Overlapping implication, checked out of reset.
`define ACL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acl assertion failed");

// Non-overlapping implication: the consequence is checked in the cycle after the antecedent.
`define ACL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acl assertion failed");

`endif

FILE: hw/rtl/acl_pkg.sv
`default_nettype none

package acl_pkg;

  // Number of table entries; one cell of the chain per entry.
  localparam int unsigned Entries = 16;

  localparam int unsigned AddrW   = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned PrefixW = 8;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 5;
  // Wide enough to hold any cell position up to the largest table.
  localparam int unsigned PosW    = 9;

  localparam logic [PrefixW-1:0] MaxPrefixV4 = 8'd32;
  localparam logic [PrefixW-1:0] MaxPrefixV6 = 8'd128;

  localparam logic ModeWrite  = 1'b0;
  localparam logic ModeLookup = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgEntryCount  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgDefaultDeny = 8'd1;

  typedef struct packed {
    logic             is_ipv6;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic             is_ipv6;
    logic [AddrW-1:0] addr;
    logic             hit;
  } query_t;

  function automatic logic [PrefixW-1:0] sat_prefix(input logic is_ipv6,
                                                    input logic [PrefixW-1:0] plen);
    logic [PrefixW-1:0] cap;
    cap = is_ipv6 ? MaxPrefixV6 : MaxPrefixV4;
    return (plen > cap) ? cap : plen;
  endfunction

  // Leading-ones mask of plen bits, most significant bit first.
  function automatic logic [AddrW-1:0] prefix_mask(input logic [PrefixW-1:0] plen);
    logic [AddrW-1:0] m;
    for (int j = 0; j < AddrW; j++) begin
      m[AddrW-1-j] = (9'(j) < {1'b0, plen});
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/acl_cell.sv
`default_nettype none

module acl_cell (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    we_i,
  input  wire acl_pkg::entry_t   entry_i,
  input  wire                    active_i,
  input  wire acl_pkg::query_t   query_i,
  output acl_pkg::query_t        query_o
);
  import acl_pkg::*;

  entry_t           entry_q;
  logic             valid_q;
  logic             v6_q;
  logic [AddrW-1:0] addr_q;
  logic             hit_q;
  logic             match;

  always_comb begin
    match = active_i && (entry_q.is_ipv6 == query_i.is_ipv6) &&
            (((query_i.addr ^ entry_q.addr) & entry_q.mask) == '0);
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= query_i.valid;
    end
  end

  // The lookup word moves one cell on every cycle, picking up this entry's verdict.
  always_ff @(posedge clk_i) begin
    v6_q   <= query_i.is_ipv6;
    addr_q <= query_i.addr;
    hit_q  <= query_i.hit | match;
  end

  always_comb begin
    query_o.valid   = valid_q;
    query_o.is_ipv6 = v6_q;
    query_o.addr    = addr_q;
    query_o.hit     = hit_q;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ip_prefix_acl_match.sv
// Latency: a lookup word's result is presented Entries cycles after acceptance (16 as built).
// Throughput: one lookup per Entries + 2 cycles at best (18), set by the walk along the row
// of entry cells and by the result word, which must be taken before the next lookup enters.
// A write word is taken in one cycle, whenever no lookup is walking the row.
// Reset clears the entry count, the deny-when-empty flag and all handshake state; table
// entries hold no reset value and must be written before they are searched.
`default_nettype none

`include "ip_prefix_acl_match_macros.svh"

module ip_prefix_acl_match (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire                         mode_i,
  input  wire [acl_pkg::IndexW-1:0]   index_i,
  input  wire                         is_ipv6_i,
  input  wire [acl_pkg::HalfW-1:0]    addr_high_i,
  input  wire [acl_pkg::HalfW-1:0]    addr_low_i,
  input  wire [acl_pkg::PrefixW-1:0]  prefix_len_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic                        allowed_o,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [acl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [acl_pkg::CfgDatW-1:0]  cfg_data_i
);
  import acl_pkg::*;

  logic [CountW-1:0] count_q;
  logic              deny_q;
  logic              busy_q;
  logic              out_valid_q;
  logic              allowed_q;

  logic              in_fire;
  logic              lookup_fire;
  logic              write_fire;
  logic              last_valid;
  entry_t            wr_entry;
  query_t            chain [Entries+1];
  logic [Entries-1:0] we;
  logic [Entries-1:0] active;
  logic [Entries-1:0] tok_vld;

  // A write may pass while a result waits; a lookup needs the output free.
  assign in_ready_o  = !busy_q && ((mode_i == ModeWrite) || !out_valid_q);
  assign in_fire     = in_valid_i && in_ready_o;
  assign lookup_fire = in_fire && (mode_i == ModeLookup);
  assign write_fire  = in_fire && (mode_i == ModeWrite);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    wr_entry.is_ipv6 = is_ipv6_i;
    wr_entry.addr    = {addr_high_i, addr_low_i};
    wr_entry.mask    = prefix_mask(sat_prefix(is_ipv6_i, prefix_len_i));
  end

  assign chain[0] = {lookup_fire, is_ipv6_i, addr_high_i, addr_low_i, 1'b0};

  for (genvar k = 0; k < Entries; k++) begin : g_cell
    assign we[k]      = write_fire && (PosW'(index_i) == PosW'(k));
    assign active[k]  = PosW'(count_q) > PosW'(k);
    assign tok_vld[k] = chain[k+1].valid;

    acl_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .we_i     (we[k]),
      .entry_i  (wr_entry),
      .active_i (active[k]),
      .query_i  (chain[k]),
      .query_o  (chain[k+1])
    );
  end

  assign last_valid = chain[Entries].valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      deny_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgEntryCount) begin
        count_q <= cfg_data_i[CountW-1:0];
      end else if (cfg_index_i == CfgDefaultDeny) begin
        deny_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (lookup_fire) begin
        busy_q <= 1'b1;
      end else if (last_valid) begin
        busy_q <= 1'b0;
      end
      if (last_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // An empty table answers from the deny-when-empty flag alone.
  always_ff @(posedge clk_i) begin
    if (last_valid) begin
      allowed_q <= (count_q == '0) ? !deny_q : chain[Entries].hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign allowed_o   = allowed_q;

  `ACL_ASSERT_NOW(a_single_word, clk_i, rst_ni, 1'b1, $onehot0(tok_vld))
  `ACL_ASSERT_NOW(a_word_while_busy, clk_i, rst_ni, |tok_vld, busy_q)
  `ACL_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, last_valid, out_valid_o && !busy_q)

endmodule

`default_nettype wire
